// File: sv/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared widths, op codes, coefficients, sine table and round/saturate helpers
// for the Clarke/Park transform unit.
// ----------------------------------------------------------------------------
package cpt_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ANGLE_W    = 16;
   localparam int VEC_W      = SAMPLE_W + 2;
   localparam int PWR_W      = 2 * VEC_W;
   localparam int OPND_W     = VEC_W;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int CF_SHIFT   = 15;
   localparam int ROUND_HALF = 1 << (CF_SHIFT - 1);
   localparam int SH_W       = SUM_W - CF_SHIFT;
   localparam int OP_W       = 2;

   localparam int ROM_DEPTH  = 256;
   localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);
   localparam int ROM_ADDR_W = ROM_IDX_W + 1;
   localparam int POS_W      = ANGLE_W - 2;
   localparam int QUARTER    = 1 << POS_W;
   localparam int ROM_VAL_W  = CF_SHIFT + 2;
   localparam int TRIG_W     = ROM_VAL_W + 1;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 200;

   localparam logic [OP_W-1:0] OP_FWD = 2'd0;
   localparam logic [OP_W-1:0] OP_INV = 2'd1;
   localparam logic [OP_W-1:0] OP_PWR = 2'd2;

   // Q.15 coefficients: sqrt(2/3), half of it, sqrt(2/3)*sqrt(3)/2
   localparam logic signed [OPND_W-1:0] K_G = 18'sd26755;
   localparam logic signed [OPND_W-1:0] K_H = 18'sd13378;
   localparam logic signed [OPND_W-1:0] K_R = 18'sd23170;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [PWR_W-1:0]  pwr_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic [ROM_VAL_W-1:0]     sine_rom_type [0:ROM_DEPTH];

   // Quarter-wave sine, Q1.15, Horner series in Q30
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      for (int k = 0; k <= ROM_DEPTH; k++) begin
         x  = (HALF_PI_Q30 * 64'(k) + 64'(ROM_DEPTH / 2)) / 64'(ROM_DEPTH);
         x2 = (x * x + (64'd1 << 29)) >> 30;
         t  = ONE_Q30;
         t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
         t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
         t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
         t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
         t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
         t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
         s  = (x * t) >> 30;
         s  = (s + 64'd16384) >> 15;
         if (s > 64'd32768) begin
            s = 64'd32768;
         end
         rom[k] = s[ROM_VAL_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // round half up by 2^-15, then saturate to the vector width
   function automatic vec_type round_sat(input sum_type x);
      sum_type                 t;
      logic signed [SH_W-1:0]  sh;
      logic [SH_W-VEC_W:0]     top;
      t   = x + sum_type'(ROUND_HALF);
      sh  = t[SUM_W-1:CF_SHIFT];
      top = sh[SH_W-1:VEC_W-1];
      if ((&top) || !(|top)) begin
         return sh[VEC_W-1:0];
      end else if (sh[SH_W-1]) begin
         return {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VEC_W-1){1'b1}}};
      end
   endfunction

   function automatic pwr_type sat_pwr(input sum_type x);
      logic [SUM_W-PWR_W:0] top;
      top = x[SUM_W-1:PWR_W-1];
      if ((&top) || !(|top)) begin
         return x[PWR_W-1:0];
      end else if (x[SUM_W-1]) begin
         return {1'b1, {(PWR_W-1){1'b0}}};
      end else begin
         return {1'b0, {(PWR_W-1){1'b1}}};
      end
   endfunction

endpackage

// File: sv/cpt_trig.sv
// ----------------------------------------------------------------------------
// cpt_trig
// Registered sine and cosine lookup from the quarter-wave table.
// ----------------------------------------------------------------------------
module cpt_trig (
   input  logic                        clock,
   input  logic                        en,
   input  logic [cpt_pkg::ANGLE_W-1:0] angle,
   output cpt_pkg::trig_type           sin_ff,
   output cpt_pkg::trig_type           cos_ff
);

   function automatic cpt_pkg::trig_type lookup(input logic [cpt_pkg::ANGLE_W-1:0] th);
      logic [1:0]                       quad;
      logic [cpt_pkg::ROM_IDX_W-1:0]    idx;
      logic [cpt_pkg::ROM_ADDR_W-1:0]   addr;
      cpt_pkg::trig_type                mag;
      quad = th[cpt_pkg::ANGLE_W-1 -: 2];
      idx  = th[cpt_pkg::POS_W-1 -: cpt_pkg::ROM_IDX_W];
      addr = quad[0] ? cpt_pkg::ROM_ADDR_W'(cpt_pkg::ROM_DEPTH) - {1'b0, idx}
                     : {1'b0, idx};
      mag  = {1'b0, cpt_pkg::SINE_ROM[addr]};
      return quad[1] ? -mag : mag;
   endfunction

   cpt_pkg::trig_type sin_in;
   cpt_pkg::trig_type cos_in;

   always_comb begin
      sin_in = lookup(angle);
      cos_in = lookup(angle + cpt_pkg::ANGLE_W'(cpt_pkg::QUARTER));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

endmodule

// File: sv/cpt_mul4.sv
// ----------------------------------------------------------------------------
// cpt_mul4
// Four signed 18x18 multipliers with registered products.
// ----------------------------------------------------------------------------
module cpt_mul4 (
   input  logic              clock,
   input  logic              en,
   input  cpt_pkg::opnd_type mul_a [4],
   input  cpt_pkg::opnd_type mul_b [4],
   output cpt_pkg::prod_type prod_ff [4]
);

   cpt_pkg::prod_type prod_in [4];

   for (genvar i = 0; i < 4; i++) begin : g_lane
      assign prod_in[i] = mul_a[i] * mul_b[i];

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

endmodule

// File: sv/clarke_park_transform_unit.sv
// ----------------------------------------------------------------------------
// clarke_park_transform_unit
// Throughput: one transfer per cycle unless rsp_tready stalls the pipe; five register stages with a stall chain.
// Reset: synchronous, clears every stage valid bit; payload is not reset.
// ----------------------------------------------------------------------------
module clarke_park_transform_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // in_a, in_b, in_c, in_d, in_q, in_d2, in_q2, angle
   input  logic [cpt_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [cpt_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_alpha, out_beta, out_d, out_q, out_a, out_b, out_c,
   // out_active, out_reactive, zero pad
   output logic [cpt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic signed [cpt_pkg::SAMPLE_W-1:0] in_a;
   logic signed [cpt_pkg::SAMPLE_W-1:0] in_b;
   logic signed [cpt_pkg::SAMPLE_W-1:0] in_c;
   cpt_pkg::vec_type                    in_d;
   cpt_pkg::vec_type                    in_q;
   cpt_pkg::vec_type                    in_d2;
   cpt_pkg::vec_type                    in_q2;
   logic [cpt_pkg::ANGLE_W-1:0]         angle;

   assign in_a  = req_tdata[15:0];
   assign in_b  = req_tdata[31:16];
   assign in_c  = req_tdata[47:32];
   assign in_d  = req_tdata[65:48];
   assign in_q  = req_tdata[83:66];
   assign in_d2 = req_tdata[101:84];
   assign in_q2 = req_tdata[119:102];
   assign angle = req_tdata[135:120];

   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   assign s5_rdy     = !s5_valid_ff || rsp_tready;
   assign s4_rdy     = !s4_valid_ff || s5_rdy;
   assign s3_rdy     = !s3_valid_ff || s4_rdy;
   assign s2_rdy     = !s2_valid_ff || s3_rdy;
   assign s1_rdy     = !s1_valid_ff || s2_rdy;
   assign req_tready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_valid_ff <= req_tvalid;
         if (s2_rdy) s2_valid_ff <= s1_valid_ff;
         if (s3_rdy) s3_valid_ff <= s2_valid_ff;
         if (s4_rdy) s4_valid_ff <= s3_valid_ff;
         if (s5_rdy) s5_valid_ff <= s4_valid_ff;
      end
   end

   // stage 1: capture, trig lookup
   logic [cpt_pkg::OP_W-1:0]            s1_op_ff;
   logic signed [cpt_pkg::SAMPLE_W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   cpt_pkg::vec_type                    s1_d_ff, s1_q_ff, s1_d2_ff, s1_q2_ff;
   cpt_pkg::trig_type                   s1_sin, s1_cos;

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_op_ff <= req_tuser;
         s1_a_ff  <= in_a;
         s1_b_ff  <= in_b;
         s1_c_ff  <= in_c;
         s1_d_ff  <= in_d;
         s1_q_ff  <= in_q;
         s1_d2_ff <= in_d2;
         s1_q2_ff <= in_q2;
      end
   end

   cpt_trig u_trig (
      .clock  (clock),
      .en     (s1_rdy),
      .angle  (angle),
      .sin_ff (s1_sin),
      .cos_ff (s1_cos)
   );

   // stage 2: first product bank
   cpt_pkg::opnd_type m1_a [4];
   cpt_pkg::opnd_type m1_b [4];
   cpt_pkg::prod_type s2_prod [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m1_a[i] = '0;
         m1_b[i] = '0;
      end
      unique case (s1_op_ff)
         cpt_pkg::OP_FWD: begin
            m1_a[0] = cpt_pkg::K_G;
            m1_b[0] = cpt_pkg::OPND_W'(s1_a_ff);
            m1_a[1] = cpt_pkg::K_H;
            m1_b[1] = cpt_pkg::OPND_W'(s1_b_ff) + cpt_pkg::OPND_W'(s1_c_ff);
            m1_a[2] = cpt_pkg::K_R;
            m1_b[2] = cpt_pkg::OPND_W'(s1_b_ff) - cpt_pkg::OPND_W'(s1_c_ff);
         end
         cpt_pkg::OP_INV: begin
            m1_a[0] = s1_cos;
            m1_b[0] = s1_d_ff;
            m1_a[1] = s1_sin;
            m1_b[1] = s1_q_ff;
            m1_a[2] = s1_sin;
            m1_b[2] = s1_d_ff;
            m1_a[3] = s1_cos;
            m1_b[3] = s1_q_ff;
         end
         cpt_pkg::OP_PWR: begin
            m1_a[0] = s1_d_ff;
            m1_b[0] = s1_d2_ff;
            m1_a[1] = s1_q_ff;
            m1_b[1] = s1_q2_ff;
            m1_a[2] = s1_q_ff;
            m1_b[2] = s1_d2_ff;
            m1_a[3] = s1_d_ff;
            m1_b[3] = s1_q2_ff;
         end
         default: begin
         end
      endcase
   end

   cpt_mul4 u_mul_front (
      .clock   (clock),
      .en      (s2_rdy),
      .mul_a   (m1_a),
      .mul_b   (m1_b),
      .prod_ff (s2_prod)
   );

   logic [cpt_pkg::OP_W-1:0] s2_op_ff;
   cpt_pkg::trig_type        s2_sin_ff, s2_cos_ff;

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_op_ff  <= s1_op_ff;
         s2_sin_ff <= s1_sin;
         s2_cos_ff <= s1_cos;
      end
   end

   // stage 3: alpha/beta, power
   cpt_pkg::sum_type         s3_sum0, s3_sum1;
   cpt_pkg::vec_type         s3_alpha_in, s3_beta_in;
   cpt_pkg::pwr_type         s3_active_in, s3_reactive_in;
   logic                     s2_is_pwr, s2_is_vec;

   assign s2_is_pwr = (s2_op_ff == cpt_pkg::OP_PWR);
   assign s2_is_vec = (s2_op_ff == cpt_pkg::OP_FWD) || (s2_op_ff == cpt_pkg::OP_INV);

   always_comb begin
      s3_sum0 = s2_is_pwr ? cpt_pkg::SUM_W'(s2_prod[0]) + cpt_pkg::SUM_W'(s2_prod[1])
                          : cpt_pkg::SUM_W'(s2_prod[0]) - cpt_pkg::SUM_W'(s2_prod[1]);
      s3_sum1 = s2_is_pwr ? cpt_pkg::SUM_W'(s2_prod[2]) - cpt_pkg::SUM_W'(s2_prod[3])
                          : cpt_pkg::SUM_W'(s2_prod[2]) + cpt_pkg::SUM_W'(s2_prod[3]);
      s3_alpha_in    = s2_is_vec ? cpt_pkg::round_sat(s3_sum0) : '0;
      s3_beta_in     = s2_is_vec ? cpt_pkg::round_sat(s3_sum1) : '0;
      s3_active_in   = s2_is_pwr ? cpt_pkg::sat_pwr(s3_sum0) : '0;
      s3_reactive_in = s2_is_pwr ? cpt_pkg::sat_pwr(s3_sum1) : '0;
   end

   logic [cpt_pkg::OP_W-1:0] s3_op_ff;
   cpt_pkg::trig_type        s3_sin_ff, s3_cos_ff;
   cpt_pkg::vec_type         s3_alpha_ff, s3_beta_ff;
   cpt_pkg::pwr_type         s3_active_ff, s3_reactive_ff;

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_op_ff       <= s2_op_ff;
         s3_sin_ff      <= s2_sin_ff;
         s3_cos_ff      <= s2_cos_ff;
         s3_alpha_ff    <= s3_alpha_in;
         s3_beta_ff     <= s3_beta_in;
         s3_active_ff   <= s3_active_in;
         s3_reactive_ff <= s3_reactive_in;
      end
   end

   // stage 4: second product bank
   cpt_pkg::opnd_type m2_a [4];
   cpt_pkg::opnd_type m2_b [4];
   cpt_pkg::prod_type s4_prod [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m2_a[i] = '0;
         m2_b[i] = '0;
      end
      unique case (s3_op_ff)
         cpt_pkg::OP_FWD: begin
            m2_a[0] = s3_cos_ff;
            m2_b[0] = s3_alpha_ff;
            m2_a[1] = s3_sin_ff;
            m2_b[1] = s3_beta_ff;
            m2_a[2] = s3_cos_ff;
            m2_b[2] = s3_beta_ff;
            m2_a[3] = s3_sin_ff;
            m2_b[3] = s3_alpha_ff;
         end
         cpt_pkg::OP_INV: begin
            m2_a[0] = cpt_pkg::K_G;
            m2_b[0] = s3_alpha_ff;
            m2_a[1] = cpt_pkg::K_R;
            m2_b[1] = s3_beta_ff;
            m2_a[2] = cpt_pkg::K_H;
            m2_b[2] = s3_alpha_ff;
         end
         default: begin
         end
      endcase
   end

   cpt_mul4 u_mul_back (
      .clock   (clock),
      .en      (s4_rdy),
      .mul_a   (m2_a),
      .mul_b   (m2_b),
      .prod_ff (s4_prod)
   );

   logic [cpt_pkg::OP_W-1:0] s4_op_ff;
   cpt_pkg::vec_type         s4_alpha_ff, s4_beta_ff;
   cpt_pkg::pwr_type         s4_active_ff, s4_reactive_ff;

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_op_ff       <= s3_op_ff;
         s4_alpha_ff    <= s3_alpha_ff;
         s4_beta_ff     <= s3_beta_ff;
         s4_active_ff   <= s3_active_ff;
         s4_reactive_ff <= s3_reactive_ff;
      end
   end

   // stage 5: d/q or phases, output register
   cpt_pkg::sum_type s4_w0, s4_w1, s4_w2;
   cpt_pkg::vec_type s5_d_in, s5_q_in, s5_a_in, s5_b_in, s5_c_in;

   assign s4_w0 = cpt_pkg::SUM_W'(s4_prod[0]);
   assign s4_w1 = cpt_pkg::SUM_W'(s4_prod[1]);
   assign s4_w2 = cpt_pkg::SUM_W'(s4_prod[2]);

   always_comb begin
      s5_d_in = '0;
      s5_q_in = '0;
      s5_a_in = '0;
      s5_b_in = '0;
      s5_c_in = '0;
      unique case (s4_op_ff)
         cpt_pkg::OP_FWD: begin
            s5_d_in = cpt_pkg::round_sat(s4_w0 + s4_w1);
            s5_q_in = cpt_pkg::round_sat(s4_w2 - cpt_pkg::SUM_W'(s4_prod[3]));
         end
         cpt_pkg::OP_INV: begin
            s5_a_in = cpt_pkg::round_sat(s4_w0);
            s5_b_in = cpt_pkg::round_sat(s4_w1 - s4_w2);
            s5_c_in = cpt_pkg::round_sat(-s4_w2 - s4_w1);
         end
         default: begin
         end
      endcase
   end

   logic [cpt_pkg::OP_W-1:0] s5_op_ff;
   cpt_pkg::vec_type         s5_alpha_ff, s5_beta_ff, s5_d_ff, s5_q_ff;
   cpt_pkg::vec_type         s5_a_ff, s5_b_ff, s5_c_ff;
   cpt_pkg::pwr_type         s5_active_ff, s5_reactive_ff;

   always_ff @(posedge clock) begin
      if (s5_rdy) begin
         s5_op_ff       <= s4_op_ff;
         s5_alpha_ff    <= s4_alpha_ff;
         s5_beta_ff     <= s4_beta_ff;
         s5_d_ff        <= s5_d_in;
         s5_q_ff        <= s5_q_in;
         s5_a_ff        <= s5_a_in;
         s5_b_ff        <= s5_b_in;
         s5_c_ff        <= s5_c_in;
         s5_active_ff   <= s4_active_ff;
         s5_reactive_ff <= s4_reactive_ff;
      end
   end

   assign rsp_tvalid = s5_valid_ff;
   assign rsp_tdata  = {2'b00, s5_reactive_ff, s5_active_ff, s5_c_ff, s5_b_ff, s5_a_ff,
                        s5_q_ff, s5_d_ff, s5_beta_ff, s5_alpha_ff};

   // checks
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff &&
                       s5_valid_ff && !rsp_tready))
      else $error("input stalled with a bubble in the pipe");

   a_take_s1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted transfer lost at stage 1");

   a_pwr_zero: assert property (@(posedge clock) disable iff (reset)
      (s5_valid_ff && s5_op_ff != cpt_pkg::OP_PWR) |->
         (s5_active_ff == '0 && s5_reactive_ff == '0))
      else $error("power fields nonzero for a non-power op");

   a_phase_zero: assert property (@(posedge clock) disable iff (reset)
      (s5_valid_ff && s5_op_ff != cpt_pkg::OP_INV) |->
         (s5_a_ff == '0 && s5_b_ff == '0 && s5_c_ff == '0))
      else $error("phase fields nonzero for a non-inverse op");

endmodule
